@@ rtl/rsd_pkg.sv @@
// Shared types and constants for the run/skip/dump frame decoder.
package rsd_pkg;

    // Default destination buffer size in bytes
    localparam int unsigned BUFFER_SIZE_DEF = 65536;

    // Opcode byte codes
    localparam logic [7:0] OP_SHORT_FILL = 8'h00;
    localparam logic [7:0] OP_WORD       = 8'h80;

    // Bit positions inside the 16-bit control word
    localparam int unsigned WORD_LONG_BIT = 15;
    localparam int unsigned WORD_FILL_BIT = 14;

    // Parser phase
    typedef enum logic [2:0] {
        PH_OPCODE     = 3'd0,
        PH_FILL_COUNT = 3'd1,
        PH_FILL_COLOR = 3'd2,
        PH_LITERAL    = 3'd3,
        PH_WORD_LO    = 3'd4,
        PH_WORD_HI    = 3'd5
    } t_phase;

    // Result kind
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    // Parser state other than the destination offset
    typedef struct packed {
        t_phase      phase;
        logic [13:0] remaining;
        logic [7:0]  low_byte;
    } t_parse_state;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [13:0] run_length;
        logic [7:0]  value;
        logic        overrun;
    } t_result;

endpackage

@@ rtl/rsd_in_if.sv @@
// Input byte stream channel: valid/ready with one compressed byte.
interface rsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

@@ rtl/rsd_out_if.sv @@
// Result channel: valid/ready with one decoded write, fill run or frame end.
interface rsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [13:0] run_length;
    logic [7:0]  value;
    logic        overrun;

    modport source (output valid, output kind, output address, output run_length,
                    output value, output overrun, input ready);
    modport sink   (input valid, input kind, input address, input run_length,
                    input value, input overrun, output ready);
endinterface

@@ rtl/run_skip_dump_frame_decoder.sv @@
// Top level of the run/skip/dump frame decoder.
//
// Usage: compressed frame bytes enter on i_in (valid/ready, byte_in), one
// transfer per byte. Decoded items leave on o_out: single byte writes, fill
// runs (address, run_length, color) and a frame-end marker; overrun flags any
// write or run reaching past BUFFER_SIZE. Skips and header bytes give no item.
// Throughput: one byte per cycle while i_in.ready is high, set by the
// combinational parse logic between the parser state and result registers.
// Output: the result of a byte is registered in the result register, or in
// the skid register while the result register still holds an untaken result.
// Stalls: a two-entry output buffer (result register plus skid register)
// lets a byte be taken while one result waits; i_in.ready drops only while
// both entries are full, and rises again once o_out transfers.
// Reset: synchronous, active low; the parser returns to opcode parsing with
// offset 0 and both output entries empty. No clearing pass is needed.
module run_skip_dump_frame_decoder #(
    parameter int unsigned BUFFER_SIZE = rsd_pkg::BUFFER_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsd_in_if.sink     i_in,
    rsd_out_if.source  o_out
);
    localparam int unsigned OFF_W = $clog2(BUFFER_SIZE) + 1;

    rsd_pkg::t_parse_state r_state, n_state;
    logic [OFF_W-1:0]      r_offset, n_offset;
    rsd_pkg::t_result      r_out, r_skid, new_res;
    logic                  r_out_valid, r_skid_valid;
    logic                  new_valid;
    logic                  in_xfer;
    logic                  out_xfer;

    assign i_in.ready = !r_skid_valid;
    assign in_xfer    = i_in.valid && !r_skid_valid;
    assign out_xfer   = r_out_valid && o_out.ready;

    rsd_parse #(
        .BUFFER_SIZE (BUFFER_SIZE),
        .OFF_W       (OFF_W)
    ) u_parse (
        .i_state     (r_state),
        .i_offset    (r_offset),
        .i_byte      (i_in.byte_in),
        .o_state     (n_state),
        .o_offset    (n_offset),
        .o_res_valid (new_valid),
        .o_res       (new_res)
    );

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase     <= rsd_pkg::PH_OPCODE;
            r_state.remaining <= 14'd0;
            r_state.low_byte  <= 8'd0;
            r_offset          <= '0;
        end else if (in_xfer) begin
            r_state  <= n_state;
            r_offset <= n_offset;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_xfer) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_xfer && new_valid) begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_xfer) begin
                r_out <= r_skid;
            end
        end else if (in_xfer && new_valid) begin
            if (!r_out_valid || out_xfer) begin
                r_out <= new_res;
            end else begin
                r_skid <= new_res;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out.kind;
    assign o_out.address    = r_out.address;
    assign o_out.run_length = r_out.run_length;
    assign o_out.value      = r_out.value;
    assign o_out.overrun    = r_out.overrun;

endmodule

@@ rtl/rsd_parse.sv @@
// Next-state and result logic for one compressed byte.
module rsd_parse #(
    parameter int unsigned BUFFER_SIZE = rsd_pkg::BUFFER_SIZE_DEF,
    parameter int unsigned OFF_W       = $clog2(BUFFER_SIZE) + 1
) (
    input  rsd_pkg::t_parse_state i_state,
    input  logic [OFF_W-1:0]      i_offset,
    input  logic [7:0]            i_byte,
    output rsd_pkg::t_parse_state o_state,
    output logic [OFF_W-1:0]      o_offset,
    output logic                  o_res_valid,
    output rsd_pkg::t_result      o_res
);
    localparam int unsigned SUM_W = ((OFF_W > 15) ? OFF_W : 15) + 1;
    localparam logic [SUM_W-1:0] BUF_LIM = SUM_W'(BUFFER_SIZE);

    logic [15:0]        word;
    logic [14:0]        adv_amt;
    logic [SUM_W-1:0]   sum;
    logic [OFF_W-1:0]   sat_offset;
    logic [OFF_W+15:0]  off_ext;
    logic [15:0]        address;
    logic               at_end;

    assign word    = {i_byte, i_state.low_byte};
    assign off_ext = {16'b0, i_offset};
    assign address = off_ext[15:0];
    assign at_end  = ({{(SUM_W-OFF_W){1'b0}}, i_offset} >= BUF_LIM);

    // Advance amount for this phase
    always_comb begin
        case (i_state.phase)
            rsd_pkg::PH_FILL_COLOR: adv_amt = {1'b0, i_state.remaining};
            rsd_pkg::PH_LITERAL:    adv_amt = 15'd1;
            rsd_pkg::PH_WORD_HI:    adv_amt = word[14:0];
            default:                adv_amt = {8'b0, i_byte[6:0]};
        endcase
    end

    // Saturating offset advance
    assign sum = {{(SUM_W-OFF_W){1'b0}}, i_offset} + {{(SUM_W-15){1'b0}}, adv_amt};
    assign sat_offset = (sum > BUF_LIM) ? OFF_W'(BUFFER_SIZE) : sum[OFF_W-1:0];

    // Phase decode
    always_comb begin
        o_state     = i_state;
        o_offset    = i_offset;
        o_res_valid = 1'b0;
        o_res.kind       = rsd_pkg::KIND_WRITE;
        o_res.address    = address;
        o_res.run_length = 14'd1;
        o_res.value      = i_byte;
        o_res.overrun    = 1'b0;
        unique case (i_state.phase)
            rsd_pkg::PH_FILL_COUNT: begin
                o_state.remaining = {6'b0, i_byte};
                o_state.phase     = rsd_pkg::PH_FILL_COLOR;
            end
            rsd_pkg::PH_FILL_COLOR: begin
                o_state.phase = rsd_pkg::PH_OPCODE;
                if (i_state.remaining != 14'd0) begin
                    o_res_valid       = 1'b1;
                    o_res.kind        = rsd_pkg::KIND_FILL;
                    o_res.run_length  = i_state.remaining;
                    o_res.overrun     = (sum > BUF_LIM);
                    o_offset          = sat_offset;
                    o_state.remaining = 14'd0;
                end
            end
            rsd_pkg::PH_LITERAL: begin
                o_res_valid       = 1'b1;
                o_res.overrun     = at_end;
                o_offset          = sat_offset;
                o_state.remaining = i_state.remaining - 14'd1;
                if (i_state.remaining == 14'd1) begin
                    o_state.phase = rsd_pkg::PH_OPCODE;
                end
            end
            rsd_pkg::PH_WORD_LO: begin
                o_state.low_byte = i_byte;
                o_state.phase    = rsd_pkg::PH_WORD_HI;
            end
            rsd_pkg::PH_WORD_HI: begin
                o_state.phase = rsd_pkg::PH_OPCODE;
                if (word == 16'd0) begin
                    // frame end: restart offset
                    o_res_valid       = 1'b1;
                    o_res.kind        = rsd_pkg::KIND_END;
                    o_res.address     = 16'd0;
                    o_res.run_length  = 14'd0;
                    o_res.value       = 8'd0;
                    o_offset          = '0;
                    o_state.remaining = 14'd0;
                end else if (!word[rsd_pkg::WORD_LONG_BIT]) begin
                    o_offset = sat_offset;
                end else if (word[rsd_pkg::WORD_FILL_BIT]) begin
                    o_state.remaining = word[13:0];
                    o_state.phase     = rsd_pkg::PH_FILL_COLOR;
                end else begin
                    o_state.remaining = word[13:0];
                    if (word[13:0] != 14'd0) begin
                        o_state.phase = rsd_pkg::PH_LITERAL;
                    end
                end
            end
            default: begin
                o_state.phase = rsd_pkg::PH_OPCODE;
                if (i_byte == rsd_pkg::OP_SHORT_FILL) begin
                    o_state.phase = rsd_pkg::PH_FILL_COUNT;
                end else if (!i_byte[7]) begin
                    o_state.remaining = {6'b0, i_byte};
                    o_state.phase     = rsd_pkg::PH_LITERAL;
                end else if (i_byte != rsd_pkg::OP_WORD) begin
                    o_offset = sat_offset;
                end else begin
                    o_state.phase = rsd_pkg::PH_WORD_LO;
                end
            end
        endcase
    end

endmodule
